### sv/cbt_pkg.sv
`default_nettype none

package cbt_pkg;

    localparam int unsigned CBT_W = 32;

    localparam int unsigned Q_W = 5;
    localparam logic [Q_W-1:0] QUANTA_MAX = 5'd18;
    localparam logic [Q_W-1:0] QUANTA_MIN = 5'd9;
    localparam logic [Q_W-1:0] SEG2_DIVISOR = 5'd8;
    localparam logic [Q_W-1:0] JUMP_WIDTH = 5'd2;
    localparam logic [CBT_W-1:0] PRESC_LIMIT = 32'd1024;

    localparam int unsigned SEG1_W = 4;
    localparam int unsigned PRESC_W = 10;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_ZERO_RATE  = 2'd1,
        STATUS_PRESC_ZERO = 2'd2,
        STATUS_PRESC_HIGH = 2'd3
    } status_t;

endpackage

`default_nettype wire

### sv/can_bit_timing_calculator_core.sv
// Sequence: the clock is divided by the bit rate to get ticks per bit, then one division per
// quanta trial (one to ten trials), then the output is loaded; a zero bit rate skips both.
// Throughput: one beat at a time; a new beat is taken while the last result waits.
// Both divisions run through one shared restoring divider, one quotient bit a cycle.
// Reset: asynchronous, active low; clears the sequencer and output valid.
`default_nettype none

module can_bit_timing_calculator_core
    import cbt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CBT_W-1:0]    clock_hz,
    input  wire logic [CBT_W-1:0]    bit_rate,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     jump_width_code,
    output logic [SEG1_W-1:0]        segment1_code,
    output logic                     segment2_code,
    output logic [PRESC_W-1:0]       prescaler_code,
    output logic [Q_W-1:0]           quanta_per_bit,
    output logic [1:0]               status
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RATE   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CBT_W-1:0]   ticks_reg, ticks_next;
    logic [Q_W-1:0]     q_reg, q_next;

    logic               res_sjw_reg, res_sjw_next;
    logic [SEG1_W-1:0]  res_seg1_reg, res_seg1_next;
    logic               res_seg2_reg, res_seg2_next;
    logic [PRESC_W-1:0] res_brp_reg, res_brp_next;
    logic [Q_W-1:0]     res_q_reg, res_q_next;
    status_t            res_st_reg, res_st_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_sjw_reg;
    logic [SEG1_W-1:0]  out_seg1_reg;
    logic               out_seg2_reg;
    logic [PRESC_W-1:0] out_brp_reg;
    logic [Q_W-1:0]     out_q_reg;
    status_t            out_st_reg;
    logic               out_load;

    logic               div_start;
    logic [CBT_W-1:0]   div_dividend;
    logic [CBT_W-1:0]   div_divisor;
    logic               div_done;
    logic [CBT_W-1:0]   div_quotient;
    logic [CBT_W-1:0]   div_remainder;

    logic [Q_W-1:0]     seg2_w;
    logic [Q_W-1:0]     seg1_code_w;
    logic [Q_W-1:0]     sjw_code_w;
    logic [CBT_W-1:0]   brp_code_w;

    cbt_div #(
        .WIDTH (CBT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign in_ready = (state_reg == S_IDLE);

    assign seg2_w      = q_reg / SEG2_DIVISOR;
    assign seg1_code_w = q_reg - 5'd2 - seg2_w;
    assign sjw_code_w  = JUMP_WIDTH - 5'd1;
    assign brp_code_w  = div_quotient - 32'd1;

    always_comb
    begin
        state_next    = state_reg;
        ticks_next    = ticks_reg;
        q_next        = q_reg;
        res_sjw_next  = res_sjw_reg;
        res_seg1_next = res_seg1_reg;
        res_seg2_next = res_seg2_reg;
        res_brp_next  = res_brp_reg;
        res_q_next    = res_q_reg;
        res_st_next   = res_st_reg;
        div_start     = 1'b0;
        div_dividend  = ticks_reg;
        div_divisor   = {{(CBT_W-Q_W){1'b0}}, q_reg};
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                div_dividend = clock_hz;
                div_divisor  = bit_rate;
                if (in_valid)
                begin
                    if (bit_rate == '0)
                    begin
                        res_sjw_next  = 1'b0;
                        res_seg1_next = '0;
                        res_seg2_next = 1'b0;
                        res_brp_next  = '0;
                        res_q_next    = '0;
                        res_st_next   = STATUS_ZERO_RATE;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_RATE;
                    end
                end
            end
            S_RATE:
            begin
                q_next       = QUANTA_MAX;
                div_dividend = div_quotient;
                div_divisor  = {{(CBT_W-Q_W){1'b0}}, QUANTA_MAX};
                if (div_done)
                begin
                    ticks_next = div_quotient;
                    div_start  = 1'b1;
                    state_next = S_SEARCH;
                end
                else
                begin
                    q_next = q_reg;
                end
            end
            S_SEARCH:
            begin
                if (div_done)
                begin
                    if ((div_remainder == '0) || (q_reg == QUANTA_MIN))
                    begin
                        res_sjw_next  = 1'b0;
                        res_seg1_next = '0;
                        res_seg2_next = 1'b0;
                        res_brp_next  = '0;
                        res_q_next    = '0;
                        if (div_quotient == '0)
                        begin
                            res_st_next = STATUS_PRESC_ZERO;
                        end
                        else if (div_quotient > PRESC_LIMIT)
                        begin
                            res_st_next = STATUS_PRESC_HIGH;
                        end
                        else
                        begin
                            res_sjw_next  = sjw_code_w[0];
                            res_seg1_next = seg1_code_w[SEG1_W-1:0];
                            res_seg2_next = seg2_w[0] ^ 1'b1;
                            res_brp_next  = brp_code_w[PRESC_W-1:0];
                            res_q_next    = q_reg;
                            res_st_next   = STATUS_OK;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        q_next      = q_reg - 5'd1;
                        div_divisor = {{(CBT_W-Q_W){1'b0}}, q_reg - 5'd1};
                        div_start   = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ticks_reg    <= ticks_next;
        q_reg        <= q_next;
        res_sjw_reg  <= res_sjw_next;
        res_seg1_reg <= res_seg1_next;
        res_seg2_reg <= res_seg2_next;
        res_brp_reg  <= res_brp_next;
        res_q_reg    <= res_q_next;
        res_st_reg   <= res_st_next;
        if (out_load)
        begin
            out_sjw_reg  <= res_sjw_reg;
            out_seg1_reg <= res_seg1_reg;
            out_seg2_reg <= res_seg2_reg;
            out_brp_reg  <= res_brp_reg;
            out_q_reg    <= res_q_reg;
            out_st_reg   <= res_st_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign jump_width_code = out_sjw_reg;
    assign segment1_code   = out_seg1_reg;
    assign segment2_code   = out_seg2_reg;
    assign prescaler_code  = out_brp_reg;
    assign quanta_per_bit  = out_q_reg;
    assign status          = out_st_reg;

endmodule

`default_nettype wire

### sv/cbt_div.sv
`default_nettype none

module cbt_div
    import cbt_pkg::*;
#(
    parameter int unsigned WIDTH = CBT_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);

    localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = ~diff[WIDTH];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
